@@ rtl/core/tsch_pkg.sv @@
// tsch_pkg: shared constants, field widths and sequencer state type for the
// token stream content hash. No dependencies.
`timescale 1ns / 1ps

package tsch_pkg;

   localparam int COUNT_BITS_DEF = 16;

   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   localparam int USER_FIRST_BIT = 0;
   localparam int USER_HAS_ID_BIT = 1;

   localparam logic [31:0] SEED_C   = 32'h9E37_79B9;
   localparam logic [31:0] MUL_A    = 32'hCC9E_2D51;
   localparam logic [31:0] MUL_B    = 32'h1B87_3593;
   localparam logic [31:0] LANE_LO  = 32'h2722_0A95;
   localparam logic [31:0] LANE_HI  = 32'h517C_C1B7;
   localparam logic [31:0] ID_W2    = 32'h85EB_CA6B;
   localparam logic [31:0] ID_W3    = 32'hC2B2_AE35;
   localparam logic [31:0] FIN_LO   = 32'hED55_8CCD;
   localparam logic [31:0] FIN_HI   = 32'hFF51_AFD7;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ID_MUL,
      ST_ID_ACC,
      ST_L0,
      ST_L1,
      ST_L2,
      ST_L3,
      ST_B0,
      ST_B1,
      ST_B2,
      ST_W0,
      ST_W1,
      ST_END,
      ST_F0,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4
   } phase_type;

endpackage

@@ rtl/core/tsch_mul.sv @@
// tsch_mul: shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on nothing; operands come from the sequencer.
`timescale 1ns / 1ps

module tsch_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ rtl/core/tsch_seq.sv @@
// tsch_seq: sequencer and hash state; drives the shared multiplier through
// partial products and holds the digest output register. Uses tsch_pkg.
`timescale 1ns / 1ps

module tsch_seq #(
   parameter int COUNT_BITS = tsch_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        first,
   input  logic [15:0] token_total,
   input  logic [15:0] kind,
   input  logic [15:0] length,
   input  logic        has_identifier,
   input  logic [63:0] identifier_ref,
   output logic [31:0] mul_a,
   output logic [31:0] mul_b,
   input  logic [63:0] prod,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] digest
);

   localparam int TW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   tsch_pkg::phase_type state_ff, state_in;

   logic [63:0]           acc_ff, acc_in;
   logic [63:0]           tmp_ff, tmp_in;
   logic [31:0]           fold_ff, fold_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [31:0]           gw_ff [4];
   logic [31:0]           gw_in [4];
   logic [31:0]           mixw_ff, mixw_in;
   logic [31:0]           next_word_ff, next_word_in;
   logic                  next_pend_ff, next_pend_in;
   logic [31:0]           opa_ff, opa_in;
   logic [31:0]           opb_ff, opb_in;
   logic                  grp_end_ff, grp_end_in;
   logic [31:0]           digest_ff, digest_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic [TW-1:0]         tot_ext;
   logic [COUNT_BITS-1:0] tot_new;
   logic [COUNT_BITS-1:0] eff_total;
   logic [COUNT_BITS-1:0] eff_pos;
   logic [COUNT_BITS-1:0] full_end;
   logic [COUNT_BITS-1:0] pos_next;
   logic [31:0]           eff_fold;
   logic                  in_group;
   logic [1:0]            slot;
   logic [31:0]           packed_word;
   logic [31:0]           r3;
   logic [31:0]           r5;
   logic                  active;
   logic [63:0]           prod_hi;
   logic [63:0]           fin_h;

   assign in_ready  = (state_ff == tsch_pkg::ST_IDLE);
   assign accept    = in_valid && in_ready;
   assign out_valid = rsp_valid_ff;
   assign digest    = digest_ff;

   assign tot_ext     = TW'(token_total);
   assign tot_new     = tot_ext[COUNT_BITS-1:0];
   assign eff_total   = first ? tot_new : total_ff;
   assign eff_pos     = first ? '0 : pos_ff;
   assign eff_fold    = first ? 32'h0 : fold_ff;
   assign full_end    = {eff_total[COUNT_BITS-1:2], 2'b00};
   assign in_group    = eff_pos < full_end;
   assign slot        = eff_pos[1:0];
   assign pos_next    = eff_pos + COUNT_BITS'(1);
   assign packed_word = {kind, length};
   assign r3          = identifier_ref[34:3];
   assign r5          = identifier_ref[36:5];
   assign active      = first || (pos_ff < total_ff);
   // low half of the product placed in the upper word, for the cross terms
   assign prod_hi     = {prod[31:0], 32'h0};
   assign fin_h       = tmp_ff + prod_hi;

   // multiplier operand selection
   always_comb begin
      mul_a = 32'h0;
      mul_b = 32'h0;
      unique case (state_ff)
         tsch_pkg::ST_ID_MUL: begin
            mul_a = opa_ff;
            mul_b = opb_ff;
         end
         tsch_pkg::ST_L0: begin
            mul_a = gw_ff[3];
            mul_b = tsch_pkg::LANE_LO;
         end
         tsch_pkg::ST_L1: begin
            mul_a = gw_ff[2];
            mul_b = tsch_pkg::LANE_LO;
         end
         tsch_pkg::ST_L2: begin
            mul_a = gw_ff[3];
            mul_b = tsch_pkg::LANE_HI;
         end
         tsch_pkg::ST_B0: begin
            mul_a = acc_ff[31:0];
            mul_b = tsch_pkg::MUL_B;
         end
         tsch_pkg::ST_B1: begin
            mul_a = acc_ff[63:32];
            mul_b = tsch_pkg::MUL_B;
         end
         tsch_pkg::ST_W0: begin
            mul_a = mixw_ff;
            mul_b = tsch_pkg::MUL_A;
         end
         tsch_pkg::ST_F1: begin
            mul_a = acc_ff[31:0];
            mul_b = tsch_pkg::FIN_LO;
         end
         tsch_pkg::ST_F2: begin
            mul_a = acc_ff[63:32];
            mul_b = tsch_pkg::FIN_LO;
         end
         // final state keeps issuing the same operands so the product holds
         tsch_pkg::ST_F3, tsch_pkg::ST_F4: begin
            mul_a = acc_ff[31:0];
            mul_b = tsch_pkg::FIN_HI;
         end
         default: begin
            mul_a = 32'h0;
            mul_b = 32'h0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      fold_in      = fold_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      gw_in        = gw_ff;
      mixw_in      = mixw_ff;
      next_word_in = next_word_ff;
      next_pend_in = next_pend_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      grp_end_in   = grp_end_ff;
      digest_in    = digest_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;

      unique case (state_ff)
         tsch_pkg::ST_IDLE: begin
            if (accept) begin
               if (first) begin
                  total_in = tot_new;
                  pos_in   = '0;
                  fold_in  = 32'h0;
                  acc_in   = 64'(tsch_pkg::SEED_C) ^ 64'(tot_new);
               end
               if (first && (tot_new == '0)) begin
                  state_in = tsch_pkg::ST_F0;
               end else if (active) begin
                  pos_in = pos_next;
                  if (in_group) begin
                     gw_in[slot] = packed_word;
                     grp_end_in  = (slot == 2'd3);
                     if (has_identifier && slot[1]) begin
                        opa_in   = slot[0] ? r5 : r3;
                        opb_in   = slot[0] ? tsch_pkg::ID_W3 : tsch_pkg::ID_W2;
                        state_in = tsch_pkg::ST_ID_MUL;
                     end else begin
                        if (has_identifier) begin
                           fold_in = eff_fold ^ (slot[0] ? r5 : r3);
                        end
                        if (slot == 2'd3) begin
                           state_in = tsch_pkg::ST_L0;
                        end else if (pos_next == eff_total) begin
                           state_in = tsch_pkg::ST_F0;
                        end
                     end
                  end else begin
                     // tail token: mix packed word, then the reference if any
                     mixw_in      = packed_word;
                     next_word_in = r3;
                     next_pend_in = has_identifier;
                     state_in     = tsch_pkg::ST_W0;
                  end
               end
            end
         end
         tsch_pkg::ST_ID_MUL: begin
            state_in = tsch_pkg::ST_ID_ACC;
         end
         tsch_pkg::ST_ID_ACC: begin
            fold_in  = fold_ff ^ prod[31:0];
            state_in = grp_end_ff ? tsch_pkg::ST_L0 : tsch_pkg::ST_END;
         end
         tsch_pkg::ST_L0: begin
            state_in = tsch_pkg::ST_L1;
         end
         tsch_pkg::ST_L1: begin
            tmp_in   = prod;
            state_in = tsch_pkg::ST_L2;
         end
         tsch_pkg::ST_L2: begin
            tmp_in   = tmp_ff + prod_hi;
            state_in = tsch_pkg::ST_L3;
         end
         tsch_pkg::ST_L3: begin
            acc_in       = acc_ff ^ {gw_ff[0], gw_ff[1]} ^ (tmp_ff + prod_hi);
            next_word_in = fold_ff;
            next_pend_in = (fold_ff != 32'h0);
            fold_in      = 32'h0;
            state_in     = tsch_pkg::ST_B0;
         end
         tsch_pkg::ST_B0: begin
            state_in = tsch_pkg::ST_B1;
         end
         tsch_pkg::ST_B1: begin
            tmp_in   = prod;
            state_in = tsch_pkg::ST_B2;
         end
         tsch_pkg::ST_B2: begin
            acc_in = tmp_ff + prod_hi;
            if (next_pend_ff) begin
               mixw_in      = next_word_ff;
               next_pend_in = 1'b0;
               state_in     = tsch_pkg::ST_W0;
            end else begin
               state_in = tsch_pkg::ST_END;
            end
         end
         tsch_pkg::ST_W0: begin
            state_in = tsch_pkg::ST_W1;
         end
         tsch_pkg::ST_W1: begin
            acc_in   = acc_ff ^ prod ^ (prod >> 16);
            state_in = tsch_pkg::ST_B0;
         end
         tsch_pkg::ST_END: begin
            state_in = (pos_ff == total_ff) ? tsch_pkg::ST_F0 : tsch_pkg::ST_IDLE;
         end
         tsch_pkg::ST_F0: begin
            acc_in   = acc_ff ^ (acc_ff >> 33);
            state_in = tsch_pkg::ST_F1;
         end
         tsch_pkg::ST_F1: begin
            state_in = tsch_pkg::ST_F2;
         end
         tsch_pkg::ST_F2: begin
            tmp_in   = prod;
            state_in = tsch_pkg::ST_F3;
         end
         tsch_pkg::ST_F3: begin
            tmp_in   = tmp_ff + prod_hi;
            state_in = tsch_pkg::ST_F4;
         end
         tsch_pkg::ST_F4: begin
            // wait here while the previous digest is still unclaimed
            if (!rsp_valid_ff || out_ready) begin
               digest_in    = fin_h[31:0] ^ {1'b0, fin_h[63:33]};
               rsp_valid_in = 1'b1;
               state_in     = tsch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsch_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsch_pkg::ST_IDLE;
         acc_ff       <= 64'h0;
         fold_ff      <= 32'h0;
         pos_ff       <= '0;
         total_ff     <= '0;
         next_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         fold_ff      <= fold_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         next_pend_ff <= next_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff       <= tmp_in;
      gw_ff        <= gw_in;
      mixw_ff      <= mixw_in;
      next_word_ff <= next_word_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      grp_end_ff   <= grp_end_in;
      digest_ff    <= digest_in;
   end

endmodule

@@ rtl/core/token_stream_content_hash.sv @@
// token_stream_content_hash: top level of the token stream hash engine.
// Instantiates tsch_seq and tsch_mul; uses tsch_pkg.
//
//   channel   dir  handshake              payload
//   req_      in   req_tvalid/req_tready  req_tdata (token fields), req_tuser (flags)
//   rsp_      out  rsp_tvalid/rsp_tready  rsp_tdata (32-bit digest)
//
// A grouped token in slot 0 or 1 skips the multiplier, a weighted reference in slot 2
// or 3 uses it, a group end or a tail token runs the mixes, and the last token adds
// the final avalanche, which a zero-length sequence starts at once; all are paced by
// the one shared 32x32 multiplier, two or three passes for a 64-bit operand.
// Reset is synchronous and active high and leaves the block idle with no digest.
// req_tready is high only while the sequencer is idle; a waiting digest does not
// stop the next transaction, only the next finish, which holds until it is taken.
`timescale 1ns / 1ps

module token_stream_content_hash #(
   parameter int COUNT_BITS = tsch_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // token_total[15:0], kind[31:16], length[47:32], identifier_ref[111:48]
   input  logic [tsch_pkg::REQ_DATA_W-1:0] req_tdata,
   // first[0], has_identifier[1]
   input  logic [tsch_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // digest[31:0]
   output logic [tsch_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;

   tsch_seq #(
      .COUNT_BITS (COUNT_BITS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .first          (req_tuser[tsch_pkg::USER_FIRST_BIT]),
      .token_total    (req_tdata[15:0]),
      .kind           (req_tdata[31:16]),
      .length         (req_tdata[47:32]),
      .has_identifier (req_tuser[tsch_pkg::USER_HAS_ID_BIT]),
      .identifier_ref (req_tdata[111:48]),
      .mul_a          (mul_a),
      .mul_b          (mul_b),
      .prod           (prod),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .digest         (rsp_tdata)
   );

   tsch_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

endmodule

@@ rtl/core/tsch_checker.sv @@
// tsch_checker: port-level assertions for token_stream_content_hash, bound to
// the top level below. Uses tsch_pkg for port widths.
`timescale 1ns / 1ps

module tsch_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [tsch_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [tsch_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tsch_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // no digest is on offer right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("digest offered after reset");

   // a stalled digest holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("digest dropped or changed while stalled");

   // a zero-length sequence goes straight into the finish and blocks input
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[tsch_pkg::USER_FIRST_BIT]
       && (req_tdata[15:0] == 16'h0)) |=> !req_tready)
      else $error("input taken during zero-length finish");

   // a new digest only appears after a busy cycle of the finish sequence
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("digest appeared without a finish sequence");

endmodule

bind token_stream_content_hash tsch_checker u_tsch_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
